FILE: hw/rtl/dhs_pkg.sv
package dhs_pkg;

    localparam int MAX_DEGREE = 128;
    localparam int COUNT_BITS = 32;
    localparam int DEG_W      = 8;
    localparam int BIN_N      = MAX_DEGREE + 1;
    localparam int BIN_AW     = $clog2(BIN_N);
    localparam int T_W        = COUNT_BITS + BIN_AW;
    localparam int S_W        = COUNT_BITS + 2 * BIN_AW;
    localparam int PRD_W      = 2 * S_W;
    localparam int VAL_W      = 40;
    localparam int NUM_PCT    = 9;
    localparam int PCT_W      = 7;
    localparam int THR_W      = COUNT_BITS + PCT_W;
    localparam int KIND_W     = 3;
    localparam int SLOT_W     = 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int NUM_RES    = 4 + NUM_PCT;

    localparam logic [KIND_W-1:0] KIND_COUNT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TOTAL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MEAN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SD    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PCT   = 3'd4;

    localparam logic [PCT_W-1:0] PCT_DIV = 7'd100;

    function automatic logic [PCT_W-1:0] pct_of(input logic [SLOT_W-1:0] slot);
        logic [PCT_W-1:0] p;
        case (slot)
            4'd0:    p = 7'd1;
            4'd1:    p = 7'd5;
            4'd2:    p = 7'd10;
            4'd3:    p = 7'd25;
            4'd4:    p = 7'd50;
            4'd5:    p = 7'd75;
            4'd6:    p = 7'd90;
            4'd7:    p = 7'd95;
            4'd8:    p = 7'd99;
            default: p = 7'd0;
        endcase
        return p;
    endfunction

    // Clamp a wide value to the result field.
    function automatic logic [VAL_W-1:0] sat_val(input logic [PRD_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v > PRD_W'({VAL_W{1'b1}})) begin
            r = '1;
        end else begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

    typedef struct packed {
        logic              vld;
        logic [BIN_AW-1:0] bin;
        logic              last;
    } t_node;

    typedef struct packed {
        logic  avail;
        t_node node;
    } t_fq;

    typedef struct packed {
        logic                  start;
        logic [COUNT_BITS-1:0] n;
        logic [T_W-1:0]        t;
        logic [S_W-1:0]        s;
    } t_math_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] mean;
        logic [VAL_W-1:0] sd;
    } t_math_rsp;

endpackage

FILE: hw/rtl/dhs_if.sv
interface dhs_node_if;
    logic                       valid;
    logic                       ready;
    logic                       node_counts;
    logic [dhs_pkg::DEG_W-1:0]  degree;
    logic                       last_node;

    modport source(output valid, output node_counts, output degree, output last_node,
                   input ready);
    modport sink(input valid, input node_counts, input degree, input last_node,
                 output ready);
endinterface

interface dhs_result_if;
    logic                        valid;
    logic                        ready;
    logic [dhs_pkg::KIND_W-1:0]  stat_kind;
    logic [dhs_pkg::SLOT_W-1:0]  pct_slot;
    logic [dhs_pkg::VAL_W-1:0]   stat_value;
    logic                        report_end;

    modport source(output valid, output stat_kind, output pct_slot, output stat_value,
                   output report_end, input ready);
    modport sink(input valid, input stat_kind, input pct_slot, input stat_value,
                 input report_end, output ready);
endinterface

FILE: hw/rtl/dhs_front.sv
module dhs_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dhs_node_if.sink     i_node,
    input  logic         i_block,
    input  logic         i_pop,
    output dhs_pkg::t_fq o_fq
);

    localparam int DW = dhs_pkg::BIN_AW + dhs_pkg::DEG_W;

    dhs_pkg::t_node r_q [0:dhs_pkg::FIFO_DEPTH-1];
    logic [dhs_pkg::FIFO_AW:0] r_wp;
    logic [dhs_pkg::FIFO_AW:0] r_rp;

    logic           full;
    logic           empty;
    logic           push;
    logic [DW-1:0]  deg_wide;
    dhs_pkg::t_node node_in;

    assign empty = (r_wp == r_rp);
    assign full  = (r_wp[dhs_pkg::FIFO_AW-1:0] == r_rp[dhs_pkg::FIFO_AW-1:0]) &&
                   (r_wp[dhs_pkg::FIFO_AW] != r_rp[dhs_pkg::FIFO_AW]);

    assign i_node.ready = !full && !i_block;
    assign push         = i_node.valid && i_node.ready;

    // Degrees beyond the top bin land in the top bin.
    assign deg_wide = DW'(i_node.degree);
    always_comb begin
        node_in.vld  = i_node.node_counts;
        node_in.last = i_node.last_node;
        if (deg_wide > DW'(dhs_pkg::MAX_DEGREE)) begin
            node_in.bin = dhs_pkg::BIN_AW'(dhs_pkg::MAX_DEGREE);
        end else begin
            node_in.bin = deg_wide[dhs_pkg::BIN_AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp[dhs_pkg::FIFO_AW-1:0]] <= node_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop && !empty) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    assign o_fq.avail = !empty;
    assign o_fq.node  = r_q[r_rp[dhs_pkg::FIFO_AW-1:0]];

endmodule

FILE: hw/rtl/dhs_math.sv
module dhs_math (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dhs_pkg::t_math_req i_req,
    output dhs_pkg::t_math_rsp o_rsp
);

    localparam int SW  = dhs_pkg::S_W;
    localparam int PW  = dhs_pkg::PRD_W;
    localparam int CB  = dhs_pkg::COUNT_BITS;
    localparam int CW  = $clog2(SW);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_MUL1 = 3'd1;
    localparam logic [2:0] M_MUL2 = 3'd2;
    localparam logic [2:0] M_SQRT = 3'd3;
    localparam logic [2:0] M_DIV1 = 3'd4;
    localparam logic [2:0] M_DIV2 = 3'd5;

    logic [2:0]              r_state;
    logic [CW-1:0]           r_cnt;
    logic [PW-1:0]           r_acc;
    logic [PW-1:0]           r_a;
    logic [SW-1:0]           r_mc;
    logic [SW-1:0]           r_mp;
    logic [SW+1:0]           r_rem;
    logic [SW-1:0]           r_root;
    logic [SW-1:0]           r_dvd;
    logic [SW-1:0]           r_q;
    logic [CB-1:0]           r_drem;
    logic [CB-1:0]           r_n;
    logic [dhs_pkg::T_W-1:0] r_t;
    logic [dhs_pkg::VAL_W-1:0] r_mean;
    logic [dhs_pkg::VAL_W-1:0] r_sd;
    logic                    r_done;

    logic          last_iter;
    logic [PW-1:0] acc_next;
    logic [PW-1:0] diff;
    logic [SW+1:0] sq_rem2;
    logic [SW+1:0] sq_trial;
    logic          sq_take;
    logic [CB:0]   dv_rem2;
    logic          dv_take;
    logic [SW-1:0] q_next;

    assign last_iter = (r_cnt == CW'(SW - 1));

    // Shift-add multiply, most significant multiplier bit first.
    assign acc_next = (r_acc << 1) + (r_mp[SW-1] ? PW'(r_mc) : '0);
    assign diff     = (r_a > acc_next) ? (r_a - acc_next) : '0;

    // Digit-by-digit square root, two radicand bits a step.
    assign sq_rem2  = {r_rem[SW-1:0], r_acc[PW-1 -: 2]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_take  = (sq_rem2 >= sq_trial);

    // Restoring division, one quotient bit a step.
    assign dv_rem2 = {r_drem, r_dvd[SW-1]};
    assign dv_take = (dv_rem2 >= {1'b0, r_n});
    assign q_next  = {r_q[SW-2:0], dv_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state) inside
                M_IDLE: begin
                    if (i_req.start) begin
                        r_n <= i_req.n;
                        r_t <= i_req.t;
                        if (i_req.n == '0) begin
                            r_mean <= '0;
                            r_sd   <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_mc    <= i_req.s;
                            r_mp    <= SW'(i_req.n);
                            r_acc   <= '0;
                            r_cnt   <= '0;
                            r_state <= M_MUL1;
                        end
                    end
                end
                M_MUL1: begin
                    r_acc <= acc_next;
                    r_mp  <= r_mp << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_iter) begin
                        r_a     <= acc_next;
                        r_mc    <= SW'(r_t);
                        r_mp    <= SW'(r_t);
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_state <= M_MUL2;
                    end
                end
                M_MUL2: begin
                    r_acc <= acc_next;
                    r_mp  <= r_mp << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (last_iter) begin
                        r_acc   <= diff << 16;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= M_SQRT;
                    end
                end
                M_SQRT: begin
                    r_acc <= r_acc << 2;
                    r_cnt <= r_cnt + 1'b1;
                    if (sq_take) begin
                        r_rem  <= sq_rem2 - sq_trial;
                        r_root <= {r_root[SW-2:0], 1'b1};
                    end else begin
                        r_rem  <= sq_rem2;
                        r_root <= {r_root[SW-2:0], 1'b0};
                    end
                    if (last_iter) begin
                        r_dvd   <= SW'({r_t, 8'd0});
                        r_drem  <= '0;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= M_DIV1;
                    end
                end
                M_DIV1, M_DIV2: begin
                    r_dvd  <= r_dvd << 1;
                    r_q    <= q_next;
                    r_cnt  <= r_cnt + 1'b1;
                    r_drem <= dv_take ? CB'(dv_rem2 - {1'b0, r_n}) : dv_rem2[CB-1:0];
                    if (last_iter) begin
                        r_drem <= '0;
                        r_q    <= '0;
                        r_cnt  <= '0;
                        if (r_state == M_DIV1) begin
                            r_mean  <= dhs_pkg::sat_val(PW'(q_next));
                            r_dvd   <= r_root;
                            r_state <= M_DIV2;
                        end else begin
                            r_sd    <= dhs_pkg::sat_val(PW'(q_next));
                            r_done  <= 1'b1;
                            r_state <= M_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.mean = r_mean;
    assign o_rsp.sd   = r_sd;

endmodule

FILE: hw/rtl/dhs_hist.sv
module dhs_hist (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dhs_pkg::t_fq       i_fq,
    output logic               o_pop,
    output logic               o_clearing,
    output dhs_pkg::t_math_req o_math,
    input  dhs_pkg::t_math_rsp i_math,
    dhs_result_if.source       o_result
);

    localparam int AW = dhs_pkg::BIN_AW;
    localparam int CB = dhs_pkg::COUNT_BITS;
    localparam int NP = dhs_pkg::NUM_PCT;
    localparam logic [CB-1:0] COUNT_MAX = '1;
    localparam logic [AW-1:0] TOP_BIN   = AW'(dhs_pkg::MAX_DEGREE);
    localparam logic [dhs_pkg::SLOT_W-1:0] LAST_RES = dhs_pkg::SLOT_W'(dhs_pkg::NUM_RES - 1);

    localparam logic [2:0] B_CLR   = 3'd0;
    localparam logic [2:0] B_IDLE  = 3'd1;
    localparam logic [2:0] B_INC   = 3'd2;
    localparam logic [2:0] B_SWEEP = 3'd3;
    localparam logic [2:0] B_DRAIN = 3'd4;
    localparam logic [2:0] B_START = 3'd5;
    localparam logic [2:0] B_MATH  = 3'd6;
    localparam logic [2:0] B_OUT   = 3'd7;

    logic [CB-1:0] r_mem [0:dhs_pkg::BIN_N-1];
    logic [CB-1:0] r_rdata;

    logic [2:0]              r_state;
    logic [AW-1:0]           r_idx;
    logic [CB-1:0]           r_n;
    logic [AW-1:0]           r_inc_bin;
    logic                    r_inc_last;
    logic                    r_s1_v;
    logic [AW-1:0]           r_s1_i;
    logic [2*AW-1:0]         r_s1_sq;
    logic                    r_s2_v;
    logic [AW-1:0]           r_s2_i;
    logic [CB-1:0]           r_s2_d;
    logic [dhs_pkg::T_W-1:0] r_p1;
    logic [dhs_pkg::S_W-1:0] r_p2;
    logic [dhs_pkg::T_W-1:0] r_t;
    logic [dhs_pkg::S_W-1:0] r_s;
    logic [CB-1:0]           r_cum;
    logic [dhs_pkg::THR_W-1:0] r_np [0:NP-1];
    logic [AW-1:0]           r_pct [0:NP-1];
    logic [NP-1:0]           r_found;
    logic [dhs_pkg::SLOT_W-1:0] r_oidx;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [CB-1:0] mem_wd;
    logic [AW-1:0] mem_ra;
    logic          take;
    logic          sweep_init;
    logic [CB-1:0] cum_next;
    logic [dhs_pkg::THR_W-1:0] cum_scaled;
    logic [dhs_pkg::SLOT_W-1:0] slot;

    assign take = (r_state == B_IDLE) && i_fq.avail;
    assign o_pop = take;
    assign o_clearing = (r_state == B_CLR);

    assign sweep_init = (take && !(i_fq.node.vld && r_n != COUNT_MAX) && i_fq.node.last) ||
                        ((r_state == B_INC) && r_inc_last);

    assign mem_ra = (r_state == B_IDLE) ? i_fq.node.bin : r_idx;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_idx;
        mem_wd = '0;
        if (r_state == B_CLR) begin
            mem_we = 1'b1;
        end else if (r_state == B_INC) begin
            mem_we = 1'b1;
            mem_wa = r_inc_bin;
            mem_wd = r_rdata + 1'b1;
        end else if (r_s1_v) begin
            mem_we = 1'b1;
            mem_wa = r_s1_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    assign cum_next   = r_cum + r_s2_d;
    assign cum_scaled = dhs_pkg::THR_W'(cum_next) * dhs_pkg::THR_W'(dhs_pkg::PCT_DIV) +
                        dhs_pkg::THR_W'(dhs_pkg::PCT_DIV - 1'b1);

    // Sweep pipeline and percentile thresholds: payload only.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NP; j++) begin
            r_np[j] <= dhs_pkg::THR_W'(r_n) *
                       dhs_pkg::THR_W'(dhs_pkg::pct_of(dhs_pkg::SLOT_W'(j)));
        end
        r_s1_i  <= r_idx;
        r_s1_sq <= (2*AW)'(r_idx) * (2*AW)'(r_idx);
        r_s2_i  <= r_s1_i;
        r_s2_d  <= r_rdata;
        r_p1    <= dhs_pkg::T_W'(r_rdata) * dhs_pkg::T_W'(r_s1_i);
        r_p2    <= dhs_pkg::S_W'(r_rdata) * dhs_pkg::S_W'(r_s1_sq);
        if (sweep_init) begin
            r_t   <= '0;
            r_s   <= '0;
            r_cum <= '0;
            for (int j = 0; j < NP; j++) begin
                r_pct[j] <= '0;
            end
        end else if (r_s2_v) begin
            r_t   <= r_t + r_p1;
            r_s   <= r_s + r_p2;
            r_cum <= cum_next;
            for (int j = 0; j < NP; j++) begin
                if (!r_found[j] && r_np[j] <= cum_scaled) begin
                    r_pct[j] <= r_s2_i;
                end
            end
        end
        if (take && i_fq.node.vld && r_n != COUNT_MAX) begin
            r_inc_bin  <= i_fq.node.bin;
            r_inc_last <= i_fq.node.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLR;
            r_idx   <= '0;
            r_n     <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_found <= '0;
            r_oidx  <= '0;
        end else begin
            r_s1_v <= (r_state == B_SWEEP);
            r_s2_v <= r_s1_v;
            if (sweep_init) begin
                r_found <= '0;
            end else if (r_s2_v) begin
                for (int j = 0; j < NP; j++) begin
                    if (r_np[j] <= cum_scaled) begin
                        r_found[j] <= 1'b1;
                    end
                end
            end
            unique case (r_state)
                B_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == TOP_BIN) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (take) begin
                        if (i_fq.node.vld && r_n != COUNT_MAX) begin
                            r_n     <= r_n + 1'b1;
                            r_state <= B_INC;
                        end else if (i_fq.node.last) begin
                            r_idx   <= '0;
                            r_state <= B_SWEEP;
                        end
                    end
                end
                B_INC: begin
                    if (r_inc_last) begin
                        r_idx   <= '0;
                        r_state <= B_SWEEP;
                    end else begin
                        r_state <= B_IDLE;
                    end
                end
                B_SWEEP: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == TOP_BIN) begin
                        r_state <= B_DRAIN;
                    end
                end
                B_DRAIN: begin
                    if (r_s2_v && r_s2_i == TOP_BIN) begin
                        r_state <= B_START;
                    end
                end
                B_START: begin
                    r_state <= B_MATH;
                end
                B_MATH: begin
                    if (i_math.done) begin
                        r_oidx  <= '0;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (o_result.ready) begin
                        if (r_oidx == LAST_RES) begin
                            r_n     <= '0;
                            r_state <= B_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_math.start = (r_state == B_START);
    assign o_math.n     = r_n;
    assign o_math.t     = r_t;
    assign o_math.s     = r_s;

    assign slot = r_oidx - dhs_pkg::SLOT_W'(4);

    always_comb begin
        o_result.valid      = (r_state == B_OUT);
        o_result.report_end = (r_oidx == LAST_RES);
        o_result.pct_slot   = '0;
        case (r_oidx)
            4'd0: begin
                o_result.stat_kind  = dhs_pkg::KIND_COUNT;
                o_result.stat_value = dhs_pkg::sat_val(dhs_pkg::PRD_W'(r_n));
            end
            4'd1: begin
                o_result.stat_kind  = dhs_pkg::KIND_TOTAL;
                o_result.stat_value = dhs_pkg::sat_val(dhs_pkg::PRD_W'(r_t));
            end
            4'd2: begin
                o_result.stat_kind  = dhs_pkg::KIND_MEAN;
                o_result.stat_value = i_math.mean;
            end
            4'd3: begin
                o_result.stat_kind  = dhs_pkg::KIND_SD;
                o_result.stat_value = i_math.sd;
            end
            default: begin
                o_result.stat_kind  = dhs_pkg::KIND_PCT;
                o_result.pct_slot   = slot;
                o_result.stat_value = dhs_pkg::VAL_W'(r_pct[slot]);
            end
        endcase
    end

endmodule

FILE: hw/rtl/degree_histogram_statistics.sv
// Degree histogram statistics: one graph node arrives per input beat and each valid node
// adds one to the bin of its neighbour count (counts above the top bin go to the top bin).
// A beat with last_node set closes the set and, after that node is counted, thirteen result
// beats follow: valid count, total neighbours, mean, standard deviation (both with eight
// fraction bits, truncated) and the 1, 5, 10, 25, 50, 75, 90, 95 and 99 percentiles, the
// last beat marked with report_end. With no valid nodes every value is zero. A valid node
// takes a read and then a write back of the incremented count in the bin RAM, an invalid
// one just leaves the queue; a four-entry queue lets input run ahead of that. A report
// sweeps the 129 bins (which also clears them), runs the serial multiply, square-root and
// divide unit, then sends the thirteen beats. After reset a clearing pass writes each of
// the 129 bins of the bin RAM before the first node is accepted.
module degree_histogram_statistics (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dhs_node_if.sink     i_node,
    dhs_result_if.source o_result
);

    dhs_pkg::t_fq       fq;
    logic               pop;
    logic               clearing;
    dhs_pkg::t_math_req math_req;
    dhs_pkg::t_math_rsp math_rsp;

    // Front: accepts beats, clamps the degree, queues the node.
    dhs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_node  (i_node),
        .i_block (clearing),
        .i_pop   (pop),
        .o_fq    (fq)
    );

    // Back: bin RAM, report sweep and result beats.
    dhs_hist u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fq       (fq),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_math     (math_req),
        .i_math     (math_rsp),
        .o_result   (o_result)
    );

    // Serial arithmetic for the mean and standard deviation.
    dhs_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (math_req),
        .o_rsp   (math_rsp)
    );

endmodule

FILE: hw/rtl/dhs_checker.sv
module dhs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dhs_pkg::KIND_W-1:0]  i_kind,
    input logic [dhs_pkg::SLOT_W-1:0]  i_slot,
    input logic [dhs_pkg::VAL_W-1:0]   i_value,
    input logic                        i_end
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value) && $stable(i_kind))
        else $error("result beat changed while stalled");

    // The end mark only ever sits on the last percentile.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_end |-> i_kind == dhs_pkg::KIND_PCT && i_slot == 4'd8)
        else $error("report end on wrong beat");

    // Scalar statistics carry no slot and no end mark.
    a_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != dhs_pkg::KIND_PCT |-> i_slot == '0 && !i_end)
        else $error("scalar beat with slot or end mark");

    // No input is taken in the cycle after reset; the bin RAM is being cleared.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("input accepted during clearing pass");

endmodule

bind degree_histogram_statistics dhs_checker u_dhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_node.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_kind      (o_result.stat_kind),
    .i_slot      (o_result.pct_slot),
    .i_value     (o_result.stat_value),
    .i_end       (o_result.report_end)
);
